// ===== src/downmix_hold_resampler_assert.svh =====
// assertion macros shared by the checker of the downmix hold resampler
// expects clk and rst to be visible where a macro is used
`ifndef DOWNMIX_HOLD_RESAMPLER_ASSERT_SVH
`define DOWNMIX_HOLD_RESAMPLER_ASSERT_SVH

// condition and consequence in the same cycle
`define DHR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("downmix_hold_resampler: same-cycle check failed");

// consequence in the cycle after the condition
`define DHR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("downmix_hold_resampler: next-cycle check failed");

`endif

// ===== src/dhr_pkg.sv =====
// shared types, constants and helpers of the downmix hold resampler
// no dependencies
package dhr_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int STEP_W            = 23;
  localparam int COUNT_W           = 4;
  localparam int APB_ADDR_W        = 4;
  localparam int APB_DATA_W        = 32;
  localparam int DEF_MAX_CHANNELS  = 8;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DEF_MAX_RUN       = 64;
  localparam int PHASE_HEAD_BITS   = 7;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 23'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

  typedef enum logic [1:0] {
    REG_STEP_RATIO     = 2'd0,
    REG_CHANNEL_COUNT  = 2'd1,
    REG_NARROW_SAMPLES = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_ratio;
    logic [COUNT_W-1:0] channel_count;
    logic               narrow_samples;
  } cfg_t;

  // frame sum holds up to max_channels full-scale samples
  function automatic int sum_width(input int max_channels);
    return SAMPLE_W + $clog2(max_channels);
  endfunction

  // effective channel count 1..max_channels
  function automatic int count_width(input int max_channels);
    return $clog2(max_channels + 1);
  endfunction

  // 8-bit unsigned: (b - 128) << 8, i.e. flip the top bit and shift
  function automatic logic signed [SAMPLE_W-1:0] to_q15(input logic [SAMPLE_W-1:0] raw,
                                                        input logic narrow);
    if (narrow) begin
      return {~raw[7], raw[6:0], 8'h00};
    end
    return raw;
  endfunction

endpackage

// ===== src/downmix_hold_resampler.sv =====
// Zero-order-hold sample rate converter with channel downmix. Interleaved
// channel samples (unsigned 8-bit or signed 16-bit) are taken one per cycle
// while a frame is being summed. The sum of a frame goes into a two-entry
// frame queue when its closing sample is taken; the back end divides the
// frame sum by the channel count in a serial divider (one quotient bit per
// cycle, a bit for each bit of the frame sum whatever count is configured;
// the first output of a frame is offered once the divider is done) and then
// emits the held value once per cycle, up to 64 times, as long as the output
// side takes it. Input stalls only when two completed frames are already
// waiting for the back end. No clearing pass follows reset.
// depends on dhr_pkg, dhr_front, dhr_queue, dhr_back
module downmix_hold_resampler #(
  parameter int MAX_CHANNELS  = dhr_pkg::DEF_MAX_CHANNELS,
  parameter int FRACTION_BITS = dhr_pkg::DEF_FRACTION_BITS,
  parameter int MAX_RUN       = dhr_pkg::DEF_MAX_RUN
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dhr_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [dhr_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [dhr_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic [dhr_pkg::SAMPLE_W-1:0]          raw_sample,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [dhr_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                  run_last
);
  import dhr_pkg::*;

  localparam int SUM_W   = sum_width(MAX_CHANNELS);
  localparam int CNT_W   = count_width(MAX_CHANNELS);
  localparam int ENTRY_W = SUM_W + CNT_W;

  cfg_t                    cfg;
  reg_index_t              reg_index;
  logic                    cfg_write;
  logic                    push;
  logic signed [SUM_W-1:0] push_sum;
  logic [CNT_W-1:0]        push_count;
  logic                    queue_full;
  logic                    frame_pop;
  logic                    frame_ready;
  logic [ENTRY_W-1:0]      head;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_ratio     <= STEP_RESET;
      cfg.channel_count  <= COUNT_RESET;
      cfg.narrow_samples <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_STEP_RATIO:     cfg.step_ratio     <= pwdata[STEP_W-1:0];
        REG_CHANNEL_COUNT:  cfg.channel_count  <= pwdata[COUNT_W-1:0];
        REG_NARROW_SAMPLES: cfg.narrow_samples <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_STEP_RATIO:     prdata = APB_DATA_W'(cfg.step_ratio);
      REG_CHANNEL_COUNT:  prdata = APB_DATA_W'(cfg.channel_count);
      REG_NARROW_SAMPLES: prdata = APB_DATA_W'(cfg.narrow_samples);
      default:            prdata = '0;
    endcase
  end

  dhr_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .raw_sample   (raw_sample),
    .push         (push),
    .push_sum     (push_sum),
    .push_count   (push_count),
    .queue_full   (queue_full)
  );

  dhr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_count}),
    .full      (queue_full),
    .pop       (frame_pop),
    .pop_data  (head),
    .not_empty (frame_ready)
  );

  dhr_back #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_RUN       (MAX_RUN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .frame_ready  (frame_ready),
    .frame_sum    (signed'(head[ENTRY_W-1:CNT_W])),
    .frame_count  (head[CNT_W-1:0]),
    .frame_pop    (frame_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_sample   (out_sample),
    .run_last     (run_last)
  );

endmodule

// ===== src/dhr_front.sv =====
// front end: takes channel samples, converts to q1.15 and sums frames
// depends on dhr_pkg; pushes each completed frame into the frame queue
module dhr_front #(
  parameter int MAX_CHANNELS = dhr_pkg::DEF_MAX_CHANNELS,
  localparam int SUM_W = dhr_pkg::sum_width(MAX_CHANNELS),
  localparam int CNT_W = dhr_pkg::count_width(MAX_CHANNELS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dhr_pkg::cfg_t                     cfg,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic [dhr_pkg::SAMPLE_W-1:0]      raw_sample,
  output logic                              push,
  output logic signed [SUM_W-1:0]           push_sum,
  output logic [CNT_W-1:0]                  push_count,
  input  logic                              queue_full
);
  import dhr_pkg::*;

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [SUM_W-1:0] sum;
  logic [POS_W-1:0]        pos;
  logic                    accept;
  logic [CNT_W-1:0]        eff_count;
  logic [CNT_W-1:0]        pos_inc;
  logic                    mid_frame;
  logic signed [SUM_W-1:0] sum_next;

  assign sample_stall = queue_full;
  assign accept       = sample_valid & ~queue_full;

  always_comb begin
    if (cfg.channel_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
      eff_count = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_count = CNT_W'(cfg.channel_count);
    end
  end

  assign pos_inc   = CNT_W'(pos) + CNT_W'(1);
  // a lowered count closes the frame at once with what has been summed
  assign mid_frame = pos_inc < eff_count;
  assign sum_next  = sum + SUM_W'(to_q15(raw_sample, cfg.narrow_samples));

  assign push       = accept & ~mid_frame;
  assign push_sum   = sum_next;
  assign push_count = eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      pos <= '0;
    end else if (accept) begin
      if (mid_frame) begin
        sum <= sum_next;
        pos <= POS_W'(pos_inc);
      end else begin
        sum <= '0;
        pos <= '0;
      end
    end
  end

endmodule

// ===== src/dhr_queue.sv =====
// short fifo of completed frames between front and back
// no package dependencies
module dhr_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full      = fill == FILL_W'(DEPTH);
  assign not_empty = fill != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ===== src/dhr_divider.sv =====
// serial restoring divider: frame sum by channel count, truncating toward zero
// depends on dhr_pkg; one quotient bit per cycle
module dhr_divider #(
  parameter int SUM_W = 19,
  parameter int CNT_W = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [SUM_W-1:0]            dividend,
  input  logic [CNT_W-1:0]                   divisor,
  output logic                               done,
  output logic signed [dhr_pkg::SAMPLE_W-1:0] quotient
);
  import dhr_pkg::*;

  localparam int STEP_CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]      mag;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W-1:0]      div;
  logic                  neg;
  logic                  busy;
  logic [STEP_CNT_W-1:0] steps;
  logic [CNT_W:0]        shifted;
  logic                  fits;
  logic [SUM_W-1:0]      signed_q;

  assign shifted  = {rem, mag[SUM_W-1]};
  assign fits     = shifted >= {1'b0, div};
  assign signed_q = neg ? (~mag + SUM_W'(1)) : mag;
  assign quotient = signed_q[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_CNT_W'(SUM_W);
        neg   <= dividend[SUM_W-1];
        // magnitude of the most negative sum still fits unsigned
        mag   <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
        rem   <= '0;
        div   <= divisor;
      end else if (busy) begin
        rem   <= fits ? CNT_W'(shifted - {1'b0, div}) : shifted[CNT_W-1:0];
        mag   <= {mag[SUM_W-2:0], fits};
        steps <= steps - STEP_CNT_W'(1);
        if (steps == STEP_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/dhr_back.sv =====
// back end: divides each frame, steps the phase and emits held outputs
// depends on dhr_pkg and dhr_divider; drives the result register
module dhr_back #(
  parameter int MAX_CHANNELS  = dhr_pkg::DEF_MAX_CHANNELS,
  parameter int FRACTION_BITS = dhr_pkg::DEF_FRACTION_BITS,
  parameter int MAX_RUN       = dhr_pkg::DEF_MAX_RUN,
  localparam int SUM_W = dhr_pkg::sum_width(MAX_CHANNELS),
  localparam int CNT_W = dhr_pkg::count_width(MAX_CHANNELS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dhr_pkg::cfg_t                       cfg,
  input  logic                                frame_ready,
  input  logic signed [SUM_W-1:0]             frame_sum,
  input  logic [CNT_W-1:0]                    frame_count,
  output logic                                frame_pop,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [dhr_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                run_last
);
  import dhr_pkg::*;

  localparam int PHASE_W = FRACTION_BITS + PHASE_HEAD_BITS;
  localparam int ADD_W   = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
  localparam int RUN_W   = $clog2(MAX_RUN);
  localparam logic [PHASE_W-1:0] PHASE_ONE =
    {{(PHASE_W - FRACTION_BITS - 1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [PHASE_W-1:0] PHASE_MAX = '1;

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    EMIT
  } state_t;

  state_t                       state;
  logic [PHASE_W-1:0]           phase;
  logic [RUN_W-1:0]             run;
  logic signed [SAMPLE_W-1:0]   held;
  logic                         div_done;
  logic signed [SAMPLE_W-1:0]   quotient;
  logic [PHASE_W-1:0]           phase_drop;
  logic [ADD_W-1:0]             phase_add;
  logic [PHASE_W-1:0]           phase_step;
  logic                         last;
  logic                         out_free;

  assign frame_pop = (state == IDLE) && frame_ready;

  dhr_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (frame_pop),
    .dividend (frame_sum),
    .divisor  (frame_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // a capped run can leave the phase below one; the drop then clamps at zero
  assign phase_drop = (phase >= PHASE_ONE) ? (phase - PHASE_ONE) : '0;
  assign phase_add  = ADD_W'(phase) + ADD_W'(cfg.step_ratio);
  assign phase_step = (phase_add > ADD_W'(PHASE_MAX)) ? PHASE_MAX : PHASE_W'(phase_add);
  assign last       = (phase_step >= PHASE_ONE) || (run == RUN_W'(MAX_RUN - 1));
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      phase        <= PHASE_ONE;
      run          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == EMIT && out_free) begin
        result_valid <= 1'b1;
        out_sample   <= held;
        run_last     <= last;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (frame_ready) begin
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            held  <= quotient;
            phase <= phase_drop;
            run   <= '0;
            state <= (phase_drop < PHASE_ONE) ? EMIT : IDLE;
          end
        end
        EMIT: begin
          if (out_free) begin
            phase <= phase_step;
            run   <= run + RUN_W'(1);
            if (last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/dhr_checker.sv =====
// port-level checks of the downmix hold resampler, bound to the top level
// depends on dhr_pkg and downmix_hold_resampler_assert.svh
`include "downmix_hold_resampler_assert.svh"

module dhr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [dhr_pkg::APB_ADDR_W-1:0]      paddr,
  input logic [dhr_pkg::APB_DATA_W-1:0]      pwdata,
  input logic [dhr_pkg::APB_DATA_W-1:0]      prdata,
  input logic                                pready,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic signed [dhr_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                run_last
);
  import dhr_pkg::*;

  // a written step ratio reads back on the following cycle
  `DHR_ASSERT_NEXT(step_readback, psel && penable && pwrite && pready && paddr[3:2] == REG_STEP_RATIO, paddr[3:2] != REG_STEP_RATIO || prdata[STEP_W-1:0] == $past(pwdata[STEP_W-1:0]))

  // a stalled result holds its value and its run marker
  `DHR_ASSERT_NEXT(result_hold, result_valid && result_stall, result_valid && $stable(out_sample) && $stable(run_last))

  // nothing is offered right after reset
  `DHR_ASSERT_SAME(quiet_after_reset, $fell(rst), !result_valid)

endmodule

bind downmix_hold_resampler dhr_checker u_checker (.*);
